>>> hdl/dftc_pkg.sv
package dftc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ADDR_W     = 10;
  localparam int BIN_W      = 10;
  localparam int TW_W       = 16;
  localparam int PROD_W     = SAMPLE_W + TW_W;
  localparam int ACC_W      = 42;
  localparam int POINTS_DEF = 1024;

  // shift count for the step reduction, walks from BIN_W-1 down to zero
  localparam int SH_W = $clog2(BIN_W);

  localparam longint Q30_ONE      = 64'sd1073741824;
  localparam longint Q30_HALF_PI  = 64'sd1686629713;
  localparam int     TAYLOR_TERMS = 12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
  } mac_stat_t;

  // restoring long division for non-negative operands
  function automatic longint udiv(input longint num, input longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'sd1;
      end
    end
    return quo;
  endfunction

  // truncating q30 series for cos (odd = 0) or sin (odd = 1) of a in [0, pi/2)
  function automatic longint taylor(input longint a, input logic odd);
    longint term;
    longint sum;
    longint d;
    term = odd ? a : Q30_ONE;
    sum  = 0;
    for (int i = 0; i < TAYLOR_TERMS; i++) begin
      d = odd ? longint'((2 * i + 2) * (2 * i + 3)) : longint'((2 * i + 1) * (2 * i + 2));
      if ((i % 2) == 1) sum = sum - term;
      else sum = sum + term;
      term = (term * a) >>> 30;
      term = (term * a) >>> 30;
      term = udiv(term, d);
    end
    return sum;
  endfunction

  function automatic logic signed [TW_W-1:0] q30_to_q15(input longint v);
    longint c;
    longint r;
    c = v;
    if (c < 0) c = 0;
    if (c > Q30_ONE) c = Q30_ONE;
    r = (c + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    return TW_W'(r);
  endfunction

endpackage

>>> hdl/dftc_store.sv
module dftc_store #(
  parameter int POINTS = dftc_pkg::POINTS_DEF,
  localparam int PH_W  = $clog2(POINTS)
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [PH_W-1:0]                         waddr_i,
  input  logic signed [dftc_pkg::SAMPLE_W-1:0]    wdata_i,
  input  logic [PH_W-1:0]                         raddr_i,
  output logic signed [dftc_pkg::SAMPLE_W-1:0]    rdata_o
);

  logic signed [dftc_pkg::SAMPLE_W-1:0] mem [POINTS];
  logic signed [dftc_pkg::SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/dftc_twiddle.sv
module dftc_twiddle #(
  parameter int POINTS = dftc_pkg::POINTS_DEF,
  localparam int PH_W  = $clog2(POINTS)
) (
  input  logic                                clk_i,
  input  logic [PH_W-1:0]                     phase_i,
  output logic signed [dftc_pkg::TW_W-1:0]    cos_o,
  output logic signed [dftc_pkg::TW_W-1:0]    sin_o
);

  logic signed [dftc_pkg::TW_W-1:0] cos_rom [POINTS];
  logic signed [dftc_pkg::TW_W-1:0] sin_rom [POINTS];
  logic signed [dftc_pkg::TW_W-1:0] cos_q;
  logic signed [dftc_pkg::TW_W-1:0] sin_q;

  // full-circle table, quadrant folded from a first-quadrant series
  for (genvar j = 0; j < POINTS; j++) begin : g_rom
    localparam longint T = 4 * j;
    localparam longint Q = T / POINTS;
    localparam longint R = T - Q * POINTS;
    localparam longint A = (dftc_pkg::Q30_HALF_PI * R + POINTS / 2) / POINTS;
    localparam logic signed [dftc_pkg::TW_W-1:0] C =
      dftc_pkg::q30_to_q15(dftc_pkg::taylor(A, 1'b0));
    localparam logic signed [dftc_pkg::TW_W-1:0] S =
      dftc_pkg::q30_to_q15(dftc_pkg::taylor(A, 1'b1));
    localparam logic signed [dftc_pkg::TW_W-1:0] CV =
      (Q == 0) ? C : (Q == 1) ? -S : (Q == 2) ? -C : S;
    localparam logic signed [dftc_pkg::TW_W-1:0] SV =
      (Q == 0) ? S : (Q == 1) ? C : (Q == 2) ? -S : -C;
    assign cos_rom[j] = CV;
    assign sin_rom[j] = SV;
  end

  always_ff @(posedge clk_i) begin
    cos_q <= cos_rom[phase_i];
    sin_q <= sin_rom[phase_i];
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

>>> hdl/dftc_mac.sv
module dftc_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  dftc_pkg::mac_ctrl_t                     ctrl_i,
  input  logic signed [dftc_pkg::SAMPLE_W-1:0]    x_i,
  input  logic signed [dftc_pkg::TW_W-1:0]        cos_i,
  input  logic signed [dftc_pkg::TW_W-1:0]        sin_i,
  output dftc_pkg::mac_stat_t                     stat_o,
  output logic signed [dftc_pkg::ACC_W-1:0]       acc_re_o,
  output logic signed [dftc_pkg::ACC_W-1:0]       acc_im_o
);

  localparam int EXT_W = dftc_pkg::ACC_W - dftc_pkg::PROD_W;

  logic                                  pvld_q;
  logic signed [dftc_pkg::PROD_W-1:0]    prod_re_q;
  logic signed [dftc_pkg::PROD_W-1:0]    prod_im_q;
  logic signed [dftc_pkg::PROD_W-1:0]    prod_re_d;
  logic signed [dftc_pkg::PROD_W-1:0]    prod_im_d;
  logic signed [dftc_pkg::ACC_W-1:0]     acc_re_q;
  logic signed [dftc_pkg::ACC_W-1:0]     acc_im_q;
  logic signed [dftc_pkg::ACC_W-1:0]     ext_re;
  logic signed [dftc_pkg::ACC_W-1:0]     ext_im;

  assign prod_re_d = x_i * cos_i;
  assign prod_im_d = x_i * sin_i;
  assign ext_re    = {{EXT_W{prod_re_q[dftc_pkg::PROD_W-1]}}, prod_re_q};
  assign ext_im    = {{EXT_W{prod_im_q[dftc_pkg::PROD_W-1]}}, prod_im_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_re_q <= prod_re_d;
    prod_im_q <= prod_im_d;
    if (ctrl_i.clr) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (pvld_q) begin
      // imaginary part takes the negative sine
      acc_re_q <= acc_re_q + ext_re;
      acc_im_q <= acc_im_q - ext_im;
    end
  end

  assign stat_o.busy = pvld_q;
  assign acc_re_o    = acc_re_q;
  assign acc_im_o    = acc_im_q;

endmodule

>>> hdl/dft_bin_calculator.sv
// channel | valid     | stall      | payload
// in      | in_valid_i | in_stall_o | func_i, sample_addr_i, sample_value_i, bin_index_i
// out     | out_valid_o| out_stall_i| bin_number_o, bin_real_o, bin_imag_o
//
// a write beat does not stall the input; a compute beat runs ten compare-subtract
// steps for the phase step, streams one sample per cycle through the mac, then
// drains the read and multiply stages
// a finished bin waits in the output register while new beats are taken; if the
// one before is still stalled there, the block holds in drain
// reset clears the control state only, the sample store is not initialised
module dft_bin_calculator #(
  parameter int POINTS = dftc_pkg::POINTS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    func_i,
  input  logic [dftc_pkg::ADDR_W-1:0]             sample_addr_i,
  input  logic signed [dftc_pkg::SAMPLE_W-1:0]    sample_value_i,
  input  logic [dftc_pkg::BIN_W-1:0]              bin_index_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [dftc_pkg::BIN_W-1:0]              bin_number_o,
  output logic signed [dftc_pkg::ACC_W-1:0]       bin_real_o,
  output logic signed [dftc_pkg::ACC_W-1:0]       bin_imag_o
);

  localparam int PH_W  = $clog2(POINTS);
  localparam int CNT_W = PH_W + 1;

  dftc_pkg::state_e state_q, state_d;

  logic [dftc_pkg::BIN_W-1:0]   k_q, k_d;
  logic [dftc_pkg::BIN_W-1:0]   rem_q, rem_d;
  logic [dftc_pkg::SH_W-1:0]    sh_q, sh_d;
  logic [PH_W-1:0]              phase_q, phase_d;
  logic [PH_W-1:0]              step_q, step_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic                         rd_vld_q;
  logic                         issue;
  logic                         out_valid_q, out_valid_d;
  logic                         load;
  logic [dftc_pkg::BIN_W-1:0]   bin_number_q;
  logic signed [dftc_pkg::ACC_W-1:0] real_q;
  logic signed [dftc_pkg::ACC_W-1:0] imag_q;

  logic                         in_accept;
  logic                         we;
  logic [31:0]                  lim;
  logic [PH_W:0]                phase_sum;

  logic signed [dftc_pkg::SAMPLE_W-1:0] x;
  logic signed [dftc_pkg::TW_W-1:0]     tw_cos;
  logic signed [dftc_pkg::TW_W-1:0]     tw_sin;
  logic signed [dftc_pkg::ACC_W-1:0]    acc_re;
  logic signed [dftc_pkg::ACC_W-1:0]    acc_im;
  dftc_pkg::mac_ctrl_t                  mac_ctrl;
  dftc_pkg::mac_stat_t                  mac_stat;

  assign in_stall_o = (state_q != dftc_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign we         = in_accept && !func_i && (32'(sample_addr_i) < POINTS);

  assign lim       = 32'(POINTS) << sh_q;
  assign phase_sum = {1'b0, phase_q} + {1'b0, step_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dftc_pkg::ST_IDLE;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= issue;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    rem_q   <= rem_d;
    sh_q    <= sh_d;
    phase_q <= phase_d;
    step_q  <= step_d;
    cnt_q   <= cnt_d;
    if (load) begin
      bin_number_q <= k_q;
      real_q       <= acc_re;
      imag_q       <= acc_im;
    end
  end

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    rem_d        = rem_q;
    sh_d         = sh_q;
    phase_d      = phase_q;
    step_d       = step_q;
    cnt_d        = cnt_q;
    issue        = 1'b0;
    load         = 1'b0;
    mac_ctrl.clr = 1'b0;
    mac_ctrl.vld = rd_vld_q;
    case (state_q)
      dftc_pkg::ST_IDLE: begin
        if (in_accept && func_i) begin
          k_d     = bin_index_i;
          rem_d   = bin_index_i;
          sh_d    = dftc_pkg::SH_W'(dftc_pkg::BIN_W - 1);
          state_d = dftc_pkg::ST_PREP;
        end
      end
      dftc_pkg::ST_PREP: begin
        // bin mod POINTS by shifted compare-subtract
        mac_ctrl.clr = 1'b1;
        if (32'(rem_q) >= lim) rem_d = rem_q - lim[dftc_pkg::BIN_W-1:0];
        sh_d = sh_q - 1'b1;
        if (sh_q == '0) begin
          step_d  = PH_W'(rem_d);
          phase_d = '0;
          cnt_d   = '0;
          state_d = dftc_pkg::ST_RUN;
        end
      end
      dftc_pkg::ST_RUN: begin
        issue   = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        phase_d = (phase_sum >= (PH_W + 1)'(POINTS)) ?
                  PH_W'(phase_sum - (PH_W + 1)'(POINTS)) : PH_W'(phase_sum);
        if (cnt_q == CNT_W'(POINTS - 1)) state_d = dftc_pkg::ST_DRAIN;
      end
      dftc_pkg::ST_DRAIN: begin
        if (!rd_vld_q && !mac_stat.busy && (!out_valid_q || !out_stall_i)) begin
          load    = 1'b1;
          state_d = dftc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dftc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (load) out_valid_d = 1'b1;
  end

  dftc_store #(
    .POINTS (POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (PH_W'(sample_addr_i)),
    .wdata_i (sample_value_i),
    .raddr_i (cnt_q[PH_W-1:0]),
    .rdata_o (x)
  );

  dftc_twiddle #(
    .POINTS (POINTS)
  ) u_twiddle (
    .clk_i   (clk_i),
    .phase_i (phase_q),
    .cos_o   (tw_cos),
    .sin_o   (tw_sin)
  );

  dftc_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .x_i      (x),
    .cos_i    (tw_cos),
    .sin_i    (tw_sin),
    .stat_o   (mac_stat),
    .acc_re_o (acc_re),
    .acc_im_o (acc_im)
  );

  assign out_valid_o  = out_valid_q;
  assign bin_number_o = bin_number_q;
  assign bin_real_o   = real_q;
  assign bin_imag_o   = imag_q;

endmodule

>>> hdl/dftc_checker.sv
module dftc_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid_i,
  input logic                                    in_stall_o,
  input logic                                    func_i,
  input logic [dftc_pkg::ADDR_W-1:0]             sample_addr_i,
  input logic signed [dftc_pkg::SAMPLE_W-1:0]    sample_value_i,
  input logic [dftc_pkg::BIN_W-1:0]              bin_index_i,
  input logic                                    out_valid_o,
  input logic                                    out_stall_i,
  input logic [dftc_pkg::BIN_W-1:0]              bin_number_o,
  input logic signed [dftc_pkg::ACC_W-1:0]       bin_real_o,
  input logic signed [dftc_pkg::ACC_W-1:0]       bin_imag_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bin_number_o) &&
    $stable(bin_real_o) && $stable(bin_imag_o))
    else $error("stalled result beat changed");

  // a compute beat makes the block busy
  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i |=> in_stall_o)
    else $error("compute beat did not occupy the block");

  // a sample write never blocks the next beat
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !func_i |=> !in_stall_o)
    else $error("sample write stalled the input");

  // a new result appears only as the block finishes a bin
  a_result_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $fell(in_stall_o))
    else $error("result beat without end of compute");

endmodule

bind dft_bin_calculator dftc_checker u_dftc_checker (.*);
